@@ rtl/adl_pkg.sv @@
// Shared types, codes, character constants and classifiers for the assembler description lexer.
`default_nettype none

package adl_pkg;

	typedef enum logic [2:0] {
		M_IDLE,
		M_CODE,
		M_IDENT,
		M_DEC,
		M_ZERO,
		M_ZEROX,
		M_HEX,
		M_COMMENT
	} lex_mode_t;

	typedef enum logic [1:0] {
		SEG_PRE,
		SEG_MID,
		SEG_POST
	} seg_t;

	localparam logic [1:0] REC_VALUE   = 2'd0;
	localparam logic [1:0] REC_DONE    = 2'd1;
	localparam logic [1:0] REC_COMMENT = 2'd2;

	localparam logic [4:0] K_END    = 5'd0;
	localparam logic [4:0] K_BAD    = 5'd1;
	localparam logic [4:0] K_CODE   = 5'd2;
	localparam logic [4:0] K_IDENT  = 5'd3;
	localparam logic [4:0] K_DEC    = 5'd4;
	localparam logic [4:0] K_HEX    = 5'd5;
	localparam logic [4:0] K_BSLASH = 5'd6;
	localparam logic [4:0] K_DOLLAR = 5'd7;
	localparam logic [4:0] K_COMMA  = 5'd8;
	localparam logic [4:0] K_PCT    = 5'd9;
	localparam logic [4:0] K_LT     = 5'd10;
	localparam logic [4:0] K_GT     = 5'd11;
	localparam logic [4:0] K_LBRACE = 5'd12;
	localparam logic [4:0] K_RBRACE = 5'd13;
	localparam logic [4:0] K_HASH   = 5'd14;
	localparam logic [4:0] K_AT     = 5'd15;
	localparam logic [4:0] K_COLON  = 5'd16;
	localparam logic [4:0] K_EOL    = 5'd17;
	localparam logic [4:0] K_LPAREN = 5'd18;
	localparam logic [4:0] K_RPAREN = 5'd19;
	localparam logic [4:0] K_LBRACK = 5'd20;
	localparam logic [4:0] K_RBRACK = 5'd21;

	localparam logic [7:0] CH_NUL    = 8'h00;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_NL     = 8'h0A;
	localparam logic [7:0] CH_VT     = 8'h0B;
	localparam logic [7:0] CH_FF     = 8'h0C;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_HASH   = 8'h23;
	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_PCT    = 8'h25;
	localparam logic [7:0] CH_LPAREN = 8'h28;
	localparam logic [7:0] CH_RPAREN = 8'h29;
	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_DOT    = 8'h2E;
	localparam logic [7:0] CH_COLON  = 8'h3A;
	localparam logic [7:0] CH_LT     = 8'h3C;
	localparam logic [7:0] CH_GT     = 8'h3E;
	localparam logic [7:0] CH_AT     = 8'h40;
	localparam logic [7:0] CH_X_UP   = 8'h58;
	localparam logic [7:0] CH_LBRACK = 8'h5B;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_RBRACK = 8'h5D;
	localparam logic [7:0] CH_USCORE = 8'h5F;
	localparam logic [7:0] CH_N_LO   = 8'h6E;
	localparam logic [7:0] CH_X_LO   = 8'h78;
	localparam logic [7:0] CH_LBRACE = 8'h7B;
	localparam logic [7:0] CH_RBRACE = 8'h7D;

	localparam int LINE_MAX_W  = 32;
	localparam int COL_MAX_W   = 16;
	localparam int CNT_W       = 5;
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = 2;

	// One queue entry describes all records that one source byte causes:
	// an optional completion, a run of characters, and another optional completion.
	typedef struct packed {
		logic                  pre_v;
		logic [4:0]            pre_kind;
		logic                  pre_bad;
		logic [LINE_MAX_W-1:0] pre_line;
		logic [COL_MAX_W-1:0]  pre_col;
		logic [1:0]            mid_type;
		logic [7:0]            mid_char;
		logic [CNT_W-1:0]      mid_cnt;
		logic                  mid_esc;
		logic                  post_v;
		logic [4:0]            post_kind;
		logic [LINE_MAX_W-1:0] post_line;
		logic [COL_MAX_W-1:0]  post_col;
	} cmd_t;

	function automatic logic is_letter(input logic [7:0] c);
		return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A) ||
			c == CH_DOT || c == CH_USCORE;
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return c >= 8'h30 && c <= 8'h39;
	endfunction

	function automatic logic is_hex(input logic [7:0] c);
		return is_digit(c) || (c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46);
	endfunction

	function automatic logic is_blank(input logic [7:0] c);
		return c == CH_SPACE || c == CH_TAB || c == CH_FF || c == CH_VT;
	endfunction

	// Returns K_END for bytes that are not punctuation.
	function automatic logic [4:0] punct_kind(input logic [7:0] c);
		logic [4:0] k;
		unique case (c)
			CH_BSLASH: k = K_BSLASH;
			CH_DOLLAR: k = K_DOLLAR;
			CH_COMMA:  k = K_COMMA;
			CH_PCT:    k = K_PCT;
			CH_LT:     k = K_LT;
			CH_GT:     k = K_GT;
			CH_LBRACE: k = K_LBRACE;
			CH_RBRACE: k = K_RBRACE;
			CH_HASH:   k = K_HASH;
			CH_AT:     k = K_AT;
			CH_COLON:  k = K_COLON;
			CH_NL:     k = K_EOL;
			CH_LPAREN: k = K_LPAREN;
			CH_RPAREN: k = K_RPAREN;
			CH_LBRACK: k = K_LBRACK;
			CH_RBRACK: k = K_RBRACK;
			default:   k = K_END;
		endcase
		return k;
	endfunction

endpackage

`default_nettype wire

@@ rtl/adl_stream_if.sv @@
// Valid/ready channel interfaces for source bytes and lexer records.
`default_nettype none

interface adl_char_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_char;
	logic       end_of_input;

	modport source (output valid, output in_char, output end_of_input, input ready);
	modport sink (input valid, input in_char, input end_of_input, output ready);
	modport monitor (input valid, input in_char, input end_of_input, input ready);
endinterface

interface adl_rec_if #(
	parameter int LINE_BITS = 20,
	parameter int COL_BITS  = 12
);
	logic                 valid;
	logic                 ready;
	logic [1:0]           record_type;
	logic [7:0]           out_char;
	logic [4:0]           token_kind;
	logic [LINE_BITS-1:0] begin_line;
	logic [COL_BITS-1:0]  begin_col;
	logic                 bad_suffix;
	logic                 last;

	modport source (output valid, output record_type, output out_char, output token_kind,
		output begin_line, output begin_col, output bad_suffix, output last, input ready);
	modport sink (input valid, input record_type, input out_char, input token_kind,
		input begin_line, input begin_col, input bad_suffix, input last, output ready);
	modport monitor (input valid, input record_type, input out_char, input token_kind,
		input begin_line, input begin_col, input bad_suffix, input last, input ready);
endinterface

`default_nettype wire

@@ rtl/adl_front.sv @@
// Lexer front end: accepts source bytes, tracks position and mode, and queues record commands.
`default_nettype none

module adl_front import adl_pkg::*; #(
	parameter int LINE_BITS = 20,
	parameter int COL_BITS  = 12,
	parameter int TAB_WIDTH = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	adl_char_if.sink    chars,
	input  logic        full,
	output logic        push,
	output cmd_t        cmd
);

	localparam int PH_W        = $clog2(TAB_WIDTH);
	localparam int COL_MAX_MOD = ((1 << COL_BITS) - 1) % TAB_WIDTH;
	localparam logic [LINE_BITS-1:0] LINE_MAX = {LINE_BITS{1'b1}};
	localparam logic [COL_BITS-1:0]  COL_MAX  = {COL_BITS{1'b1}};
	localparam logic [PH_W-1:0]      PH_SAT   = PH_W'(COL_MAX_MOD);
	localparam logic [PH_W-1:0]      PH_ONE   = PH_W'(1 % TAB_WIDTH);
	localparam logic [PH_W-1:0]      PH_LAST  = PH_W'(TAB_WIDTH - 1);
	localparam logic [CNT_W-1:0]     TAB_CNT  = CNT_W'(TAB_WIDTH);

	lex_mode_t            mode_q, mode_d;
	logic [LINE_BITS-1:0] cur_line_q, line_d;
	logic [COL_BITS-1:0]  cur_col_q, col_d;
	logic [PH_W-1:0]      phase_q, phase_d;
	logic [LINE_BITS-1:0] tok_line_q, tok_line_d;
	logic [COL_BITS-1:0]  tok_col_q, tok_col_d;

	logic [7:0]       c;
	logic             accept, step_en, eof_en;
	logic             c_letter, c_digit, c_hex, c_blank, c_alnum, c_nl, c_tab, c_nul, c_x;
	logic [4:0]       pk;
	logic             col1;
	logic [CNT_W-1:0] tab_cnt;
	logic [COL_BITS:0] col_sum;

	logic       keep, fin, fin_bad, eof_pend, start;
	logic [4:0] fin_kind, eof_kind;
	lex_mode_t  keep_mode;

	logic       st_tok, st_mid, st_post;
	logic [4:0] st_post_kind;
	lex_mode_t  st_mode;

	assign c           = chars.in_char;
	assign chars.ready = !full;
	assign accept      = chars.valid && chars.ready;
	assign step_en     = accept && !chars.end_of_input && c != CH_CR;
	assign eof_en      = accept && chars.end_of_input;

	assign c_letter = is_letter(c);
	assign c_digit  = is_digit(c);
	assign c_hex    = is_hex(c);
	assign c_blank  = is_blank(c);
	assign c_alnum  = c_letter || c_digit;
	assign c_nl     = c == CH_NL;
	assign c_tab    = c == CH_TAB;
	assign c_nul    = c == CH_NUL;
	assign c_x      = c == CH_X_LO || c == CH_X_UP;
	assign pk       = punct_kind(c);
	assign col1     = cur_col_q == COL_BITS'(1);
	assign tab_cnt  = TAB_CNT - CNT_W'(phase_q);
	assign start    = mode_q == M_IDLE || fin;

	// What the byte does to a token in progress.
	always_comb begin
		keep      = 1'b0;
		fin       = 1'b0;
		fin_kind  = K_BAD;
		fin_bad   = 1'b0;
		keep_mode = mode_q;
		eof_pend  = 1'b0;
		eof_kind  = K_BAD;
		unique case (mode_q)
			M_CODE: begin
				eof_pend = 1'b1;
				eof_kind = K_CODE;
			end
			M_IDENT: begin
				keep     = c_alnum;
				fin      = !c_alnum;
				fin_kind = K_IDENT;
				eof_pend = 1'b1;
				eof_kind = K_IDENT;
			end
			M_DEC: begin
				keep     = c_digit;
				fin      = !c_digit;
				fin_kind = K_DEC;
				fin_bad  = c_alnum;
				eof_pend = 1'b1;
				eof_kind = K_DEC;
			end
			M_ZERO: begin
				keep      = c_x;
				keep_mode = M_ZEROX;
				fin       = !c_x;
				fin_kind  = K_DEC;
				fin_bad   = c_alnum;
				eof_pend  = 1'b1;
				eof_kind  = K_DEC;
			end
			M_ZEROX: begin
				keep      = c_hex;
				keep_mode = M_HEX;
				fin       = !c_hex;
				fin_kind  = K_BAD;
				fin_bad   = c_alnum;
				eof_pend  = 1'b1;
				eof_kind  = K_BAD;
			end
			M_HEX: begin
				keep     = c_hex;
				fin      = !c_hex;
				fin_kind = K_HEX;
				fin_bad  = c_alnum;
				eof_pend = 1'b1;
				eof_kind = K_HEX;
			end
			default: begin
			end
		endcase
	end

	// What the byte starts when it arrives between tokens.
	always_comb begin
		st_tok       = 1'b1;
		st_mid       = 1'b0;
		st_post      = 1'b0;
		st_post_kind = K_BAD;
		st_mode      = M_IDLE;
		if (c_nul || (!col1 && c_blank)) begin
			st_tok = 1'b0;
		end else if (col1 && c_blank) begin
			st_mode = M_CODE;
			st_mid  = 1'b1;
		end else if (c_letter) begin
			st_mode = M_IDENT;
			st_mid  = 1'b1;
		end else if (c_digit) begin
			st_mode = (c == 8'h30) ? M_ZERO : M_DEC;
			st_mid  = 1'b1;
		end else if (col1 && c == CH_HASH) begin
			st_mode = M_COMMENT;
		end else if (pk != K_END) begin
			st_mid       = !c_nl;
			st_post      = 1'b1;
			st_post_kind = pk;
		end else begin
			st_post = 1'b1;
		end
	end

	// Next state: mode, token start and position.
	always_comb begin
		mode_d     = mode_q;
		tok_line_d = tok_line_q;
		tok_col_d  = tok_col_q;
		line_d     = cur_line_q;
		col_d      = cur_col_q;
		phase_d    = phase_q;
		col_sum    = {1'b0, cur_col_q} + (c_tab ? (COL_BITS + 1)'(tab_cnt) : (COL_BITS + 1)'(1));
		if (eof_en) begin
			mode_d = M_IDLE;
		end else if (step_en) begin
			if ((mode_q == M_CODE || mode_q == M_COMMENT) && c_nl) begin
				mode_d = M_IDLE;
			end else if (keep) begin
				mode_d = keep_mode;
			end
			if (start) begin
				mode_d = st_mode;
				if (st_tok) begin
					tok_line_d = cur_line_q;
					tok_col_d  = cur_col_q;
				end
			end
			if (c_nl) begin
				line_d  = (cur_line_q == LINE_MAX) ? cur_line_q : cur_line_q + LINE_BITS'(1);
				col_d   = COL_BITS'(1);
				phase_d = PH_ONE;
			end else if (col_sum > {1'b0, COL_MAX}) begin
				col_d   = COL_MAX;
				phase_d = PH_SAT;
			end else begin
				col_d = col_sum[COL_BITS-1:0];
				if (c_tab) begin
					phase_d = '0;
				end else begin
					phase_d = (phase_q == PH_LAST) ? '0 : phase_q + PH_W'(1);
				end
			end
		end
	end

	// Record command for the accepted byte.
	always_comb begin
		cmd = '0;
		if (eof_en) begin
			cmd.pre_v     = eof_pend;
			cmd.pre_kind  = eof_kind;
			cmd.pre_line  = LINE_MAX_W'(tok_line_q);
			cmd.pre_col   = COL_MAX_W'(tok_col_q);
			cmd.post_v    = 1'b1;
			cmd.post_kind = K_END;
			cmd.post_line = LINE_MAX_W'(cur_line_q);
			cmd.post_col  = COL_MAX_W'(cur_col_q);
		end else if (step_en) begin
			cmd.pre_line = LINE_MAX_W'(tok_line_q);
			cmd.pre_col  = COL_MAX_W'(tok_col_q);
			cmd.mid_type = REC_VALUE;
			cmd.mid_char = c;
			if (mode_q == M_CODE) begin
				if (c_nl) begin
					cmd.pre_v    = 1'b1;
					cmd.pre_kind = K_CODE;
				end else if (c_tab) begin
					cmd.mid_char = CH_SPACE;
					cmd.mid_cnt  = tab_cnt;
				end else begin
					cmd.mid_cnt = CNT_W'(1);
				end
			end else if (mode_q == M_COMMENT) begin
				cmd.mid_type = REC_COMMENT;
				if (c_nl) begin
					cmd.mid_char = CH_BSLASH;
					cmd.mid_cnt  = CNT_W'(2);
					cmd.mid_esc  = 1'b1;
				end else begin
					cmd.mid_cnt = CNT_W'(1);
				end
			end else if (keep) begin
				cmd.mid_cnt = CNT_W'(1);
			end else begin
				cmd.pre_v    = fin;
				cmd.pre_kind = fin_kind;
				cmd.pre_bad  = fin_bad;
				if (start) begin
					if (st_mid) begin
						if (c_tab) begin
							cmd.mid_char = CH_SPACE;
							cmd.mid_cnt  = tab_cnt;
						end else begin
							cmd.mid_cnt = CNT_W'(1);
						end
					end
					cmd.post_v    = st_post;
					cmd.post_kind = st_post_kind;
					cmd.post_line = LINE_MAX_W'(cur_line_q);
					cmd.post_col  = COL_MAX_W'(cur_col_q);
				end
			end
		end
	end

	assign push = cmd.pre_v || cmd.mid_cnt != '0 || cmd.post_v;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= M_IDLE;
			cur_line_q <= LINE_BITS'(1);
			cur_col_q  <= COL_BITS'(1);
			phase_q    <= PH_ONE;
			tok_line_q <= LINE_BITS'(1);
			tok_col_q  <= COL_BITS'(1);
		end else begin
			mode_q     <= mode_d;
			cur_line_q <= line_d;
			cur_col_q  <= col_d;
			phase_q    <= phase_d;
			tok_line_q <= tok_line_d;
			tok_col_q  <= tok_col_d;
		end
	end

endmodule

`default_nettype wire

@@ rtl/adl_queue.sv @@
// Short command queue between the lexer front end and the record back end.
`default_nettype none

module adl_queue import adl_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t wr_cmd,
	output logic full,
	input  logic pop,
	output cmd_t head,
	output logic empty
);

	cmd_t              entry_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QPTR_W:0]   count_q;
	logic              do_push, do_pop;

	assign full    = count_q == (QPTR_W + 1)'(QUEUE_DEPTH);
	assign empty   = count_q == '0;
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign head    = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= wr_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + (QPTR_W + 1)'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - (QPTR_W + 1)'(1);
			end
		end
	end

endmodule

`default_nettype wire

@@ rtl/adl_back.sv @@
// Lexer back end: turns queued commands into registered records, one per cycle unless stalled.
`default_nettype none

module adl_back import adl_pkg::*; #(
	parameter int LINE_BITS = 20,
	parameter int COL_BITS  = 12
) (
	input  logic      clk,
	input  logic      arst_n,
	input  cmd_t      head,
	input  logic      empty,
	output logic      pop,
	adl_rec_if.source recs
);

	logic                 pre_done_q;
	logic [CNT_W-1:0]     rep_q;
	seg_t                 seg;
	logic                 rec_last, adv;

	logic                 out_valid_q;
	logic [1:0]           type_q;
	logic [7:0]           char_q;
	logic [4:0]           kind_q;
	logic [LINE_BITS-1:0] line_q;
	logic [COL_BITS-1:0]  col_q;
	logic                 bad_q;
	logic                 last_q;

	always_comb begin
		if (!pre_done_q && head.pre_v) begin
			seg = SEG_PRE;
		end else if (rep_q < head.mid_cnt) begin
			seg = SEG_MID;
		end else begin
			seg = SEG_POST;
		end
	end

	always_comb begin
		unique case (seg)
			SEG_PRE:  rec_last = head.mid_cnt == '0 && !head.post_v;
			SEG_MID:  rec_last = (rep_q + CNT_W'(1)) == head.mid_cnt && !head.post_v;
			default:  rec_last = 1'b1;
		endcase
	end

	assign adv = !empty && (!out_valid_q || recs.ready);
	assign pop = adv && rec_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pre_done_q  <= 1'b0;
			rep_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (adv) begin
				out_valid_q <= 1'b1;
				if (rec_last) begin
					pre_done_q <= 1'b0;
					rep_q      <= '0;
				end else begin
					pre_done_q <= 1'b1;
					if (seg == SEG_MID) begin
						rep_q <= rep_q + CNT_W'(1);
					end
				end
			end else if (recs.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			last_q <= rec_last;
			unique case (seg)
				SEG_PRE: begin
					type_q <= REC_DONE;
					char_q <= CH_NUL;
					kind_q <= head.pre_kind;
					line_q <= LINE_BITS'(head.pre_line);
					col_q  <= COL_BITS'(head.pre_col);
					bad_q  <= head.pre_bad;
				end
				SEG_MID: begin
					type_q <= head.mid_type;
					char_q <= (head.mid_esc && rep_q != '0) ? CH_N_LO : head.mid_char;
					kind_q <= K_END;
					line_q <= '0;
					col_q  <= '0;
					bad_q  <= 1'b0;
				end
				default: begin
					type_q <= REC_DONE;
					char_q <= CH_NUL;
					kind_q <= head.post_kind;
					line_q <= LINE_BITS'(head.post_line);
					col_q  <= COL_BITS'(head.post_col);
					bad_q  <= 1'b0;
				end
			endcase
		end
	end

	assign recs.valid       = out_valid_q;
	assign recs.record_type = type_q;
	assign recs.out_char    = char_q;
	assign recs.token_kind  = kind_q;
	assign recs.begin_line  = line_q;
	assign recs.begin_col   = col_q;
	assign recs.bad_suffix  = bad_q;
	assign recs.last        = last_q;

endmodule

`default_nettype wire

@@ rtl/assembler_description_lexer_core.sv @@
// Top level of the assembler description lexer: front end, command queue and record back end.
//
// The lexer takes one source byte per transaction and can accept a byte in every cycle. Each
// byte is classified in the cycle it is accepted and becomes at most one queued command; the
// back end turns a command into its records at one record per cycle while the record side is
// ready, so a byte that causes several records (a tab in a code line gives up to TAB_WIDTH
// spaces, a comment newline gives two characters, a token that ends as another begins gives a
// completion plus the new token's records) holds the record side until all of them are out.
// The four-entry command queue absorbs such bursts; the byte side stalls only when it is full.
// Bytes that cause no record (carriage returns, blanks between tokens, the hash that opens a
// comment) queue nothing. The first record of a byte is written into the command queue and
// then into the back end's output register, from which it is shown on the record side.
`default_nettype none

module assembler_description_lexer_core import adl_pkg::*; #(
	parameter int LINE_BITS = 20,
	parameter int COL_BITS  = 12,
	parameter int TAB_WIDTH = 8
) (
	input  logic      clk,
	input  logic      arst_n,
	adl_char_if.sink  char_stream,
	adl_rec_if.source rec_stream
);

	logic push, full, pop, empty;
	cmd_t wr_cmd, head;

	adl_front #(
		.LINE_BITS (LINE_BITS),
		.COL_BITS  (COL_BITS),
		.TAB_WIDTH (TAB_WIDTH)
	) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.chars  (char_stream),
		.full   (full),
		.push   (push),
		.cmd    (wr_cmd)
	);

	adl_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wr_cmd (wr_cmd),
		.full   (full),
		.pop    (pop),
		.head   (head),
		.empty  (empty)
	);

	adl_back #(
		.LINE_BITS (LINE_BITS),
		.COL_BITS  (COL_BITS)
	) u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.empty  (empty),
		.pop    (pop),
		.recs   (rec_stream)
	);

endmodule

`default_nettype wire

@@ rtl/adl_checker.sv @@
// Port-level assertions on the lexer record channel, bound to the top level.
`default_nettype none

module adl_checker import adl_pkg::*; #(
	parameter int LINE_BITS = 20,
	parameter int COL_BITS  = 12
) (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 valid,
	input logic                 ready,
	input logic [1:0]           record_type,
	input logic [7:0]           out_char,
	input logic [4:0]           token_kind,
	input logic [LINE_BITS-1:0] begin_line,
	input logic [COL_BITS-1:0]  begin_col,
	input logic                 bad_suffix,
	input logic                 last
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid && !ready |=> valid && $stable(record_type) &&
		$stable(out_char) && $stable(token_kind) && $stable(begin_line) &&
		$stable(begin_col) && $stable(bad_suffix) && $stable(last))
		else $error("Record changed while stalled.");

	a_char_fields: assert property (@(posedge clk) disable iff (!arst_n)
		valid && record_type != REC_DONE |-> token_kind == K_END &&
		begin_line == '0 && begin_col == '0 && !bad_suffix)
		else $error("Character record carries token fields.");

	a_done_fields: assert property (@(posedge clk) disable iff (!arst_n)
		valid && record_type == REC_DONE |-> begin_line != '0 &&
		begin_col != '0 && out_char == CH_NUL)
		else $error("Completion record has a bad position or character.");

	a_end_last: assert property (@(posedge clk) disable iff (!arst_n)
		valid && record_type == REC_DONE && token_kind == K_END |-> last)
		else $error("End-of-input token is not the last record of its byte.");

	a_suffix_kind: assert property (@(posedge clk) disable iff (!arst_n)
		valid && bad_suffix |-> record_type == REC_DONE &&
		(token_kind == K_DEC || token_kind == K_HEX || token_kind == K_BAD))
		else $error("Suffix flag on a token that is not a number.");

endmodule

bind assembler_description_lexer_core adl_checker #(
	.LINE_BITS (LINE_BITS),
	.COL_BITS  (COL_BITS)
) u_adl_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.valid       (rec_stream.valid),
	.ready       (rec_stream.ready),
	.record_type (rec_stream.record_type),
	.out_char    (rec_stream.out_char),
	.token_kind  (rec_stream.token_kind),
	.begin_line  (rec_stream.begin_line),
	.begin_col   (rec_stream.begin_col),
	.bad_suffix  (rec_stream.bad_suffix),
	.last        (rec_stream.last)
);

`default_nettype wire

@@ tb/lexer_tb_pkg.sv @@
// Record type and token scoreboard that predicts and checks the lexer's record stream.
package lexer_tb_pkg;
	import adl_pkg::*;

	localparam int TB_LINE_BITS = 20;
	localparam int TB_COL_BITS  = 12;
	localparam int TB_TAB       = 8;
	localparam int unsigned COL_TOP = (1 << TB_COL_BITS) - 1;

	typedef struct packed {
		logic [1:0]              record_type;
		logic [7:0]              out_char;
		logic [4:0]              token_kind;
		logic [TB_LINE_BITS-1:0] begin_line;
		logic [TB_COL_BITS-1:0]  begin_col;
		logic                    bad_suffix;
		logic                    last;
	} lex_rec_t;

	class lexer_scoreboard;
		lex_mode_t               mode;
		logic [TB_LINE_BITS-1:0] cur_line;
		logic [TB_LINE_BITS-1:0] tok_line;
		int unsigned             cur_col;
		int unsigned             byte_col;
		int unsigned             tok_col;
		lex_rec_t                awaited[$];
		lex_rec_t                step_recs[$];
		int unsigned             errors;
		int unsigned             bytes_in;
		int unsigned             end_marks;
		int unsigned             records_ok;
		int unsigned             productive;
		bit [21:0]               kinds_done;

		function new();
			mode = M_IDLE;
			cur_line = 1;
			tok_line = 1;
			cur_col = 1;
			byte_col = 1;
			tok_col = 1;
			errors = 0;
			bytes_in = 0;
			end_marks = 0;
			records_ok = 0;
			productive = 0;
			kinds_done = '0;
		endfunction

		function int pending();
			return awaited.size();
		endfunction

		function bit letter_byte(logic [7:0] c);
			return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z") || c == CH_DOT ||
				c == CH_USCORE;
		endfunction

		function bit digit_byte(logic [7:0] c);
			return c >= "0" && c <= "9";
		endfunction

		function bit hex_byte(logic [7:0] c);
			return digit_byte(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
		endfunction

		function bit blank_byte(logic [7:0] c);
			return c == CH_SPACE || c == CH_TAB || c == CH_FF || c == CH_VT;
		endfunction

		function logic [4:0] punct_code(logic [7:0] c);
			case (c)
				CH_BSLASH: return K_BSLASH;
				CH_DOLLAR: return K_DOLLAR;
				CH_COMMA:  return K_COMMA;
				CH_PCT:    return K_PCT;
				CH_LT:     return K_LT;
				CH_GT:     return K_GT;
				CH_LBRACE: return K_LBRACE;
				CH_RBRACE: return K_RBRACE;
				CH_HASH:   return K_HASH;
				CH_AT:     return K_AT;
				CH_COLON:  return K_COLON;
				CH_NL:     return K_EOL;
				CH_LPAREN: return K_LPAREN;
				CH_RPAREN: return K_RPAREN;
				CH_LBRACK: return K_LBRACK;
				CH_RBRACK: return K_RBRACK;
				default:   return K_END;
			endcase
		endfunction

		function void put(logic [1:0] rtype, logic [7:0] ch, logic [4:0] kind,
				logic [TB_LINE_BITS-1:0] line_no, int unsigned col, bit bad);
			lex_rec_t r;
			r.record_type = rtype;
			r.out_char = ch;
			r.token_kind = kind;
			r.begin_line = line_no;
			r.begin_col = col[TB_COL_BITS-1:0];
			r.bad_suffix = bad;
			r.last = 1'b0;
			step_recs.push_back(r);
		endfunction

		function void value_char(logic [7:0] c);
			put(REC_VALUE, c, '0, '0, 0, 1'b0);
		endfunction

		function void token_done(logic [4:0] kind, logic [TB_LINE_BITS-1:0] line_no,
				int unsigned col, bit bad);
			put(REC_DONE, '0, kind, line_no, col, bad);
			kinds_done[kind] = 1'b1;
		endfunction

		function void code_char(logic [7:0] c);
			if (c == CH_TAB) begin
				repeat (TB_TAB - byte_col % TB_TAB) value_char(CH_SPACE);
			end else begin
				value_char(c);
			end
		endfunction

		function void open_token(logic [7:0] c);
			logic [4:0] k;
			if (c == CH_NUL) return;
			if (byte_col > 1 && blank_byte(c)) return;
			tok_line = cur_line;
			tok_col = byte_col;
			if (byte_col == 1 && blank_byte(c)) begin
				mode = M_CODE;
				code_char(c);
			end else if (letter_byte(c)) begin
				mode = M_IDENT;
				value_char(c);
			end else if (digit_byte(c)) begin
				mode = (c == "0") ? M_ZERO : M_DEC;
				value_char(c);
			end else if (c == CH_HASH && byte_col == 1) begin
				mode = M_COMMENT;
			end else begin
				k = punct_code(c);
				if (k != K_END) begin
					if (c != CH_NL) value_char(c);
					token_done(k, tok_line, tok_col, 1'b0);
				end else begin
					token_done(K_BAD, tok_line, tok_col, 1'b0);
				end
			end
		endfunction

		function void close_and_reopen(logic [4:0] kind, bit bad, logic [7:0] c);
			token_done(kind, tok_line, tok_col, bad);
			mode = M_IDLE;
			open_token(c);
		endfunction

		function void move_position(logic [7:0] c);
			int unsigned stride;
			if (c == CH_NL) begin
				if (cur_line != '1) cur_line = cur_line + 1'b1;
				cur_col = 1;
			end else begin
				stride = (c == CH_TAB) ? TB_TAB - cur_col % TB_TAB : 1;
				cur_col = (cur_col + stride > COL_TOP) ? COL_TOP : cur_col + stride;
			end
		endfunction

		function void note_byte(logic [7:0] c, bit at_end);
			bit alnum;
			step_recs.delete();
			bytes_in++;
			if (at_end) begin
				end_marks++;
				case (mode)
					M_CODE:         token_done(K_CODE, tok_line, tok_col, 1'b0);
					M_IDENT:        token_done(K_IDENT, tok_line, tok_col, 1'b0);
					M_DEC, M_ZERO:  token_done(K_DEC, tok_line, tok_col, 1'b0);
					M_ZEROX:        token_done(K_BAD, tok_line, tok_col, 1'b0);
					M_HEX:          token_done(K_HEX, tok_line, tok_col, 1'b0);
					default: ;
				endcase
				mode = M_IDLE;
				token_done(K_END, cur_line, cur_col, 1'b0);
			end else if (c != CH_CR) begin
				byte_col = cur_col;
				alnum = letter_byte(c) || digit_byte(c);
				case (mode)
					M_CODE: begin
						if (c == CH_NL) begin
							token_done(K_CODE, tok_line, tok_col, 1'b0);
							mode = M_IDLE;
						end else begin
							code_char(c);
						end
					end
					M_COMMENT: begin
						if (c == CH_NL) begin
							put(REC_COMMENT, CH_BSLASH, '0, '0, 0, 1'b0);
							put(REC_COMMENT, CH_N_LO, '0, '0, 0, 1'b0);
							mode = M_IDLE;
						end else begin
							put(REC_COMMENT, c, '0, '0, 0, 1'b0);
						end
					end
					M_IDENT: begin
						if (alnum) value_char(c);
						else close_and_reopen(K_IDENT, 1'b0, c);
					end
					M_DEC: begin
						if (digit_byte(c)) value_char(c);
						else close_and_reopen(K_DEC, alnum, c);
					end
					M_ZERO: begin
						if (c == CH_X_LO || c == CH_X_UP) begin
							value_char(c);
							mode = M_ZEROX;
						end else begin
							close_and_reopen(K_DEC, alnum, c);
						end
					end
					M_ZEROX: begin
						if (hex_byte(c)) begin
							value_char(c);
							mode = M_HEX;
						end else begin
							close_and_reopen(K_BAD, alnum, c);
						end
					end
					M_HEX: begin
						if (hex_byte(c)) value_char(c);
						else close_and_reopen(K_HEX, alnum, c);
					end
					default: begin
						mode = M_IDLE;
						open_token(c);
					end
				endcase
				move_position(c);
			end
			if (step_recs.size() > 0) begin
				step_recs[step_recs.size()-1].last = 1'b1;
				productive++;
				foreach (step_recs[i]) awaited.push_back(step_recs[i]);
			end
		endfunction

		function string show(lex_rec_t r);
			return $sformatf("type=%0d char=%02h kind=%0d line=%0d col=%0d bad=%0b last=%0b",
				r.record_type, r.out_char, r.token_kind, r.begin_line, r.begin_col,
				r.bad_suffix, r.last);
		endfunction

		function void check_record(lex_rec_t got);
			lex_rec_t want;
			if (awaited.size() == 0) begin
				errors++;
				$display("%0t: unexpected record, expected none, actual %s", $time, show(got));
			end else begin
				want = awaited.pop_front();
				if (got !== want) begin
					errors++;
					$display("%0t: record mismatch, expected %s, actual %s", $time,
						show(want), show(got));
				end else begin
					records_ok++;
				end
			end
		endfunction
	endclass

endpackage

@@ tb/tb_top.sv @@
// Top-level testbench that drives source bytes into the lexer and checks every record it emits.
module tb_top;
	import adl_pkg::*;
	import lexer_tb_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 300000;
	localparam int unsigned ITEM_COUNT  = 250;

	logic        clk;
	logic        arst_n;
	bit          steady;
	int unsigned cycle_count;

	lexer_scoreboard sb;

	adl_char_if char_bus();
	adl_rec_if #(.LINE_BITS(TB_LINE_BITS), .COL_BITS(TB_COL_BITS)) rec_bus();

	assembler_description_lexer_core #(
		.LINE_BITS(TB_LINE_BITS),
		.COL_BITS(TB_COL_BITS),
		.TAB_WIDTH(TB_TAB)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.char_stream(char_bus),
		.rec_stream(rec_bus)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("assembler_description_lexer_core verification failed");
		$finish;
	end

	initial begin
		rec_bus.ready <= 1'b0;
		forever begin
			@(posedge clk);
			rec_bus.ready <= steady || ($urandom_range(99) >= 36);
		end
	end

	always @(posedge clk) begin
		lex_rec_t got;
		if (arst_n) begin
			if (char_bus.valid && char_bus.ready)
				sb.note_byte(char_bus.in_char, char_bus.end_of_input);
			if (rec_bus.valid && rec_bus.ready) begin
				got.record_type = rec_bus.record_type;
				got.out_char = rec_bus.out_char;
				got.token_kind = rec_bus.token_kind;
				got.begin_line = rec_bus.begin_line;
				got.begin_col = rec_bus.begin_col;
				got.bad_suffix = rec_bus.bad_suffix;
				got.last = rec_bus.last;
				sb.check_record(got);
			end
		end
	end

	task automatic send_byte(input logic [7:0] c, input bit at_end);
		int unsigned gap;
		if (!steady && $urandom_range(99) < 36) begin
			gap = $urandom_range(4, 1);
			char_bus.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		char_bus.valid <= 1'b1;
		char_bus.in_char <= c;
		char_bus.end_of_input <= at_end;
		do @(posedge clk); while (!char_bus.ready);
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++) send_byte(s[i], 1'b0);
	endtask

	task automatic hold_until_drained();
		char_bus.valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0) @(posedge clk);
	endtask

	task automatic send_separator();
		case ($urandom_range(9))
			0: send_byte(CH_TAB, 1'b0);
			1: send_byte(CH_FF, 1'b0);
			2: send_byte(CH_VT, 1'b0);
			3: send_byte(CH_NUL, 1'b0);
			4: send_byte(CH_CR, 1'b0);
			default: send_byte(CH_SPACE, 1'b0);
		endcase
	endtask

	task automatic send_token();
		string letters = "._abcfgqxzABCFGQXZ";
		string alnums = "._azAZ0123456789fFxX";
		string digits = "0123456789";
		string hexes = "0123456789abcdefABCDEF";
		string marks = "\\$,%<>{}#@:()[]\n";
		int n;
		case ($urandom_range(7))
			0: begin
				send_byte(letters[$urandom_range(letters.len()-1)], 1'b0);
				n = $urandom_range(5);
				repeat (n) send_byte(alnums[$urandom_range(alnums.len()-1)], 1'b0);
			end
			1: begin
				send_byte(digits[$urandom_range(9, 1)], 1'b0);
				n = $urandom_range(4);
				repeat (n) send_byte(digits[$urandom_range(9)], 1'b0);
			end
			2: begin
				send_byte("0", 1'b0);
				send_byte($urandom_range(1) ? CH_X_LO : CH_X_UP, 1'b0);
				n = $urandom_range(4, 1);
				repeat (n) send_byte(hexes[$urandom_range(hexes.len()-1)], 1'b0);
			end
			3: send_byte("0", 1'b0);
			4, 5: send_byte(marks[$urandom_range(marks.len()-1)], 1'b0);
			6: begin
				case ($urandom_range(2))
					0: send_text("42");
					1: send_text("0x7");
					default: send_text("0X");
				endcase
				send_byte(alnums[$urandom_range(alnums.len()-1)], 1'b0);
			end
			default: send_byte(8'($urandom_range(255)), 1'b0);
		endcase
	endtask

	task automatic send_line();
		int unsigned pick;
		int n;
		pick = $urandom_range(99);
		if (pick < 15) begin
			case ($urandom_range(3))
				0: send_byte(CH_TAB, 1'b0);
				1: send_byte(CH_FF, 1'b0);
				2: send_byte(CH_VT, 1'b0);
				default: send_byte(CH_SPACE, 1'b0);
			endcase
			n = $urandom_range(10, 2);
			repeat (n) begin
				if ($urandom_range(4) == 0) send_byte(CH_TAB, 1'b0);
				else send_byte(8'($urandom_range(126, 32)), 1'b0);
			end
			if ($urandom_range(3) == 0) send_byte(CH_CR, 1'b0);
			send_byte(CH_NL, 1'b0);
		end else if (pick < 27) begin
			send_byte(CH_HASH, 1'b0);
			n = $urandom_range(8, 1);
			repeat (n) send_byte(8'($urandom_range(255)), 1'b0);
			send_byte(CH_NL, 1'b0);
		end else if (pick < 85) begin
			n = $urandom_range(5, 1);
			repeat (n) begin
				send_token();
				if ($urandom_range(4) != 0) send_separator();
			end
			if ($urandom_range(3) == 0) send_byte(CH_CR, 1'b0);
			send_byte(CH_NL, 1'b0);
		end else if (pick < 94) begin
			n = $urandom_range(6, 1);
			repeat (n) send_byte(8'($urandom_range(255)), 1'b0);
		end else begin
			send_byte(8'($urandom_range(255)), 1'b1);
		end
	endtask

	initial begin
		int lines;
		sb = new();
		steady = 1'b0;
		arst_n <= 1'b0;
		char_bus.valid <= 1'b0;
		char_bus.in_char <= '0;
		char_bus.end_of_input <= 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_text(" a\tb\n");
		send_text("#x\r\n");
		send_text("a9 0x1Fq 7z 0xg\n");
		send_byte("0", 1'b0);
		send_byte(8'hFF, 1'b1);
		send_byte(8'h00, 1'b1);
		send_text("0x");
		send_byte(CH_NUL, 1'b1);
		send_byte(8'hFF, 1'b0);
		send_byte(CH_NUL, 1'b0);
		hold_until_drained();

		lines = 0;
		while (sb.bytes_in < ITEM_COUNT) begin
			steady = (lines >= 8 && lines < 20);
			send_line();
			lines++;
		end
		steady = 1'b0;
		send_byte(CH_NUL, 1'b1);

		char_bus.valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0) @(posedge clk);
		repeat (20) @(posedge clk);

		$display("Fed %0d source bytes including %0d end markers; %0d records matched.",
			sb.bytes_in, sb.end_marks, sb.records_ok);
		$display("Completed %0d of 22 token kinds across code, comment and token lines; %0d errors.",
			$countones(sb.kinds_done), sb.errors);
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("assembler_description_lexer_core verification clean");
		end else begin
			$display("assembler_description_lexer_core verification failed");
		end
		$finish;
	end

endmodule

@@ sim.f @@
rtl/adl_pkg.sv
rtl/adl_stream_if.sv
rtl/adl_front.sv
rtl/adl_queue.sv
rtl/adl_back.sv
rtl/assembler_description_lexer_core.sv
rtl/adl_checker.sv
tb/lexer_tb_pkg.sv
tb/tb_top.sv
